// File: hdl/one_bit_dpcm_decoder_core_defines.svh
// Assertion macros for the one-bit DPCM decoder core
`ifndef ONE_BIT_DPCM_DECODER_CORE_DEFINES_SVH
`define ONE_BIT_DPCM_DECODER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define ODPD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define ODPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ODPD_ASSERT(lbl, clk, rst_n, prop, msg)
`define ODPD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: hdl/odpd_pkg.sv
`timescale 1ns / 1ps

package odpd_pkg;

	localparam logic [6:0] STEP_RESET   = 7'd10;
	localparam logic [2:0] LEAK_RESET   = 3'd3;
	localparam logic [7:0] PWM_OFFSET   = 8'h80;
	localparam logic [2:0] LAST_BIT_IDX = 3'd7;

	typedef enum logic {
		REG_STEP_SIZE  = 1'b0,
		REG_LEAK_SHIFT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [6:0] step_size;
		logic [2:0] leak_shift;
	} cfg_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       start;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

	typedef struct packed {
		logic [1:0] count;
	} front_stat_t;

	typedef struct packed {
		logic       busy;
		logic [2:0] bit_cnt;
	} back_stat_t;

	// one integrator update: add or subtract the step, remove the leak, saturate
	function automatic logic signed [7:0] integ_next(
		input logic signed [7:0] cur,
		input logic              up,
		input logic [6:0]        step,
		input logic [2:0]        shift
	);
		logic signed [7:0] leak;
		logic signed [9:0] delta;
		logic signed [9:0] sum;
		leak  = cur >>> shift;
		delta = up ? $signed({3'b000, step}) : -$signed({3'b000, step});
		sum   = $signed({{2{cur[7]}}, cur}) + delta - $signed({{2{leak[7]}}, leak});
		if (sum > 10'sd127) begin
			integ_next = 8'sd127;
		end else if (sum < -10'sd128) begin
			integ_next = -8'sd128;
		end else begin
			integ_next = sum[7:0];
		end
	endfunction

endpackage

// File: hdl/odpd_front.sv
`timescale 1ns / 1ps

module odpd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            code_byte,
	input  logic                  start_of_utterance,
	input  logic                  pop,
	output odpd_pkg::q_head_t     head,
	output odpd_pkg::front_stat_t stat
);
	import odpd_pkg::*;

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       do_pop;

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign do_pop   = pop && (count_q != 2'd0);

	assign head.valid = (count_q != 2'd0);
	assign head.item  = mem_q[rd_ptr_q];
	assign stat.count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{code_byte: code_byte, start: start_of_utterance};
		end
	end

endmodule

// File: hdl/odpd_back.sv
`timescale 1ns / 1ps

module odpd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  odpd_pkg::cfg_t       cfg,
	input  odpd_pkg::q_head_t    head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           pwm_sample,
	output logic                 last_of_byte,
	output odpd_pkg::back_stat_t stat
);
	import odpd_pkg::*;

	logic              busy_q;
	logic [2:0]        bit_cnt_q;
	logic [7:0]        shift_q;
	logic signed [7:0] integ_q;
	logic              out_valid_q;
	logic [7:0]        pwm_q;
	logic              last_q;

	logic              advance;
	logic              fire;
	logic              up;
	logic signed [7:0] cur;
	logic signed [7:0] nxt;
	logic              is_last;

	// output register is free when empty or being taken
	assign advance = !out_valid_q || !out_stall;
	assign fire    = advance && (busy_q || head.valid);
	assign pop     = fire && !busy_q;
	assign up      = busy_q ? shift_q[7] : head.item.code_byte[7];
	assign cur     = (!busy_q && head.item.start) ? 8'sd0 : integ_q;
	assign nxt     = integ_next(cur, up, cfg.step_size, cfg.leak_shift);
	assign is_last = busy_q && (bit_cnt_q == LAST_BIT_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			bit_cnt_q   <= 3'd0;
			integ_q     <= 8'sd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= fire;
			end
			if (fire) begin
				integ_q <= nxt;
				if (!busy_q) begin
					busy_q    <= 1'b1;
					bit_cnt_q <= 3'd1;
				end else if (is_last) begin
					busy_q <= 1'b0;
				end else begin
					bit_cnt_q <= bit_cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			shift_q <= busy_q ? {shift_q[6:0], 1'b0} : {head.item.code_byte[6:0], 1'b0};
			pwm_q   <= nxt ^ PWM_OFFSET;
			last_q  <= is_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign pwm_sample   = pwm_q;
	assign last_of_byte = last_q;
	assign stat.busy    = busy_q;
	assign stat.bit_cnt = bit_cnt_q;

endmodule

// File: hdl/one_bit_dpcm_decoder_core.sv
`timescale 1ns / 1ps
`include "one_bit_dpcm_decoder_core_defines.svh"

// One-bit delta modulation decoder with a leaky integrator.
// Input channel (in_valid / in_stall): one word carries code_byte, eight
// 1-bit codes decoded bit 7 first, and start_of_utterance, which zeroes the
// integrator before that byte. Output channel (out_valid / out_stall): eight
// words per byte, pwm_sample as offset binary, last_of_byte on the eighth.
// Configuration: wr_en writes wr_data to register wr_index (0 step_size,
// 1 leak_shift); write only while the block is idle.
// A byte accepted into an empty block is written to the queue, then decoded
// into the output register, where its first sample becomes valid.
// Throughput: one sample per cycle while the receiver does not stall, set by the
// single integrator update that runs once per code bit. A two-entry queue in
// front takes new bytes while the decoder works.
// Reset: integrator cleared to zero, step_size 10, leak_shift 3, queue empty,
// no output valid. When the receiver stalls, the current sample holds in the
// output register and decoding pauses; the queue fills and then in_stall rises.
module one_bit_dpcm_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] code_byte,
	input  logic       start_of_utterance,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] pwm_sample,
	output logic       last_of_byte,
	input  logic       wr_en,
	input  logic       wr_index,
	input  logic [6:0] wr_data
);
	import odpd_pkg::*;

	cfg_t        cfg_q;
	q_head_t     head;
	logic        pop;
	front_stat_t front_stat;
	back_stat_t  back_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_size  <= STEP_RESET;
			cfg_q.leak_shift <= LEAK_RESET;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_STEP_SIZE:  cfg_q.step_size  <= wr_data;
				REG_LEAK_SHIFT: cfg_q.leak_shift <= wr_data[2:0];
				default: ;
			endcase
		end
	end

	odpd_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.code_byte          (code_byte),
		.start_of_utterance (start_of_utterance),
		.pop                (pop),
		.head               (head),
		.stat               (front_stat)
	);

	odpd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pwm_sample   (pwm_sample),
		.last_of_byte (last_of_byte),
		.stat         (back_stat)
	);

	`ODPD_ASSERT(a_q_bound, clk, arst_n, front_stat.count != 2'd3, "queue count out of range")
	`ODPD_ASSERT(a_last_idle, clk, arst_n, (out_valid && last_of_byte) |-> !back_stat.busy, "decoder busy after last sample")
	`ODPD_ASSERT(a_mid_busy, clk, arst_n, (out_valid && !last_of_byte) |-> back_stat.busy, "decoder idle mid byte")
	`ODPD_ASSERT(a_busy_cnt, clk, arst_n, back_stat.busy |-> (back_stat.bit_cnt != 3'd0), "bit counter zero while busy")
	`ODPD_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |=> !out_valid, "output valid during reset")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import odpd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES = 12;

	typedef struct {
		logic [7:0] pwm;
		logic       last;
	} sample_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] code_byte = 8'h00;
	logic       start_of_utterance = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] pwm_sample;
	logic       last_of_byte;
	logic       wr_en = 1'b0;
	logic       wr_index = REG_STEP_SIZE;
	logic [6:0] wr_data = 7'd0;

	// decoder state as the block should hold it
	logic [6:0]        step_cfg = STEP_RESET;
	logic [2:0]        shift_cfg = LEAK_RESET;
	logic signed [7:0] level = 8'sd0;

	item_t   byte_queue[$];
	sample_t pending_samples[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_ticket = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int cycle_count = 0;
	int err_count = 0;
	int bytes_sent = 0;
	int samples_seen = 0;
	int settings_used = 1;

	one_bit_dpcm_decoder_core dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.code_byte          (code_byte),
		.start_of_utterance (start_of_utterance),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.pwm_sample         (pwm_sample),
		.last_of_byte       (last_of_byte),
		.wr_en              (wr_en),
		.wr_index           (wr_index),
		.wr_data            (wr_data)
	);

	always #1 clk = ~clk;

	// run the eight codes of one byte through the leaky integrator, MSB first
	function automatic void decode_byte(input logic [7:0] codes, input logic clear);
		sample_t s;
		int      acc;
		int      leak;
		if (clear) begin
			level = 8'sd0;
		end
		for (int k = 7; k >= 0; k--) begin
			leak = int'(level) >>> shift_cfg;
			acc = int'(level) + (codes[k] ? int'(step_cfg) : -int'(step_cfg)) - leak;
			if (acc > 127) begin
				acc = 127;
			end else if (acc < -128) begin
				acc = -128;
			end
			level = acc[7:0];
			s.pwm = 8'(level) + PWM_OFFSET;
			s.last = (k == 0);
			pending_samples.push_back(s);
		end
	endfunction

	always @(posedge clk) begin : drive_in
		bit take;
		take = in_valid && !in_stall;
		if (take) begin
			decode_byte(code_byte, start_of_utterance);
			void'(byte_queue.pop_front());
			bytes_sent++;
		end
		// hold a stalled word as it is
		if (!(in_valid && !take)) begin
			if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				code_byte <= byte_queue[0].code_byte;
				start_of_utterance <= byte_queue[0].start;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with a long hold-off whenever a new ticket is raised
	always @(posedge clk) begin : drive_out_stall
		if (hold_ticket != hold_seen) begin
			hold_seen <= hold_ticket;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
		out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin : check_out
		sample_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_samples.size() == 0) begin
				$error("unexpected word: pwm_sample=%0d last_of_byte=%0b",
					pwm_sample, last_of_byte);
				err_count++;
			end else begin
				want = pending_samples.pop_front();
				if (pwm_sample !== want.pwm) begin
					$error("pwm_sample: expected %0d, got %0d", want.pwm, pwm_sample);
					err_count++;
				end
				if (last_of_byte !== want.last) begin
					$error("last_of_byte: expected %0b, got %0b", want.last, last_of_byte);
					err_count++;
				end
				samples_seen++;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [6:0] value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_STEP_SIZE) begin
			step_cfg = value;
		end else begin
			shift_cfg = value[2:0];
		end
	endtask

	// upper data bits of the shift write are junk the block must drop
	task automatic configure(input logic [6:0] step, input logic [2:0] shift);
		write_reg(REG_STEP_SIZE, step);
		write_reg(REG_LEAK_SHIFT, {4'($urandom_range(15)), shift});
		settings_used++;
		@(negedge clk);
	endtask

	task automatic configure_random();
		configure(7'($urandom_range(127)), 3'($urandom_range(7)));
	endtask

	task automatic push_byte(input logic [7:0] codes, input logic clear);
		item_t it;
		it.code_byte = codes;
		it.start = clear;
		byte_queue.push_back(it);
	endtask

	// utterances of random length; some bytes are flat runs to drive saturation
	task automatic queue_utterances(input int n);
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			push_byte(pick < 70 ? 8'($urandom) : (pick < 85 ? 8'hFF : 8'h00),
				i == 0 || $urandom_range(9) == 0);
		end
	endtask

	task automatic drain();
		do begin
			@(negedge clk);
		end while (byte_queue.size() != 0 || in_valid || pending_samples.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// reset settings: drive the integrator up and down to the leak limit, alternate patterns, single bits
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hAA, 1'b1);
		push_byte(8'h55, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h01, 1'b0);
		drain();

		// no leak shift: every sample lands on plus or minus the step
		configure(7'd127, 3'd0);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'hA5, 1'b0);
		drain();

		// zero step: only the leak moves the integrator
		configure(7'd0, 3'd7);
		push_byte(8'h7E, 1'b0);
		push_byte(8'h00, 1'b0);
		drain();

		configure(7'd127, 3'd7);
		push_byte(8'hFF, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		drain();

		send_idle_pct = 11;
		recv_stall_pct = 64;
		configure_random();
		queue_utterances(35);
		drain();
		configure_random();
		queue_utterances(35);
		drain();

		send_idle_pct = 64;
		recv_stall_pct = 11;
		configure(7'd0, 3'd0);
		queue_utterances(10);
		drain();
		configure_random();
		queue_utterances(65);
		drain();

		// no idling; the receiver holds off long enough to back the block up
		send_idle_pct = 0;
		recv_stall_pct = 0;
		configure(7'd1, 3'd1);
		hold_ticket++;
		queue_utterances(40);
		drain();
		configure_random();
		queue_utterances(35);
		drain();

		if (pending_samples.size() != 0) begin
			$error("%0d expected samples never arrived", pending_samples.size());
			err_count++;
		end
		$display("summary: %0d bytes decoded into %0d checked samples", bytes_sent,
			samples_seen);
		$display("summary: %0d register settings, %0d mismatches", settings_used, err_count);
		if (err_count == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

// File: one_bit_dpcm_decoder_core.f
+incdir+hdl
hdl/odpd_pkg.sv
hdl/odpd_front.sv
hdl/odpd_back.sv
hdl/one_bit_dpcm_decoder_core.sv
tb/tb_top.sv
